[hw/rtl/assert_macros.svh]
// Assertion macros shared by the freezer cartridge controller RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is high.
`define FCC_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds during reset.
`define FCC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/fcc_pkg.sv]
// Types, constants and helper functions of the freezer cartridge controller.
package fcc_pkg;

  localparam int RAM_DEPTH = 128;
  localparam int RAM_AW    = $clog2(RAM_DEPTH);

  localparam logic [12:0] IO_ROM_PAGE      = 13'(30 << 8);
  localparam logic [2:0]  WRITE_RUN_TARGET = 3'd3;
  localparam logic [2:0]  WRITE_RUN_MAX    = 3'd7;
  localparam logic [7:0]  HOLD_COUNT_MAX   = 8'hFF;

  localparam logic        HAS_SYS_ROM_RESET  = 1'b0;
  localparam logic [18:0] DEBOUNCE_RESET     = 19'd500000;
  localparam logic [7:0]  RESET_HOLD_RESET   = 8'd30;

  // configuration register indexes
  localparam logic [1:0] CFG_HAS_SYSTEM_ROM  = 2'd0;
  localparam logic [1:0] CFG_DEBOUNCE_CYCLES = 2'd1;
  localparam logic [1:0] CFG_RESET_HOLD_MIN  = 2'd2;

  // data source codes
  localparam logic [2:0] SRC_NONE     = 3'd0;
  localparam logic [2:0] SRC_LOW_ROM  = 3'd1;
  localparam logic [2:0] SRC_HIGH_ROM = 3'd2;
  localparam logic [2:0] SRC_SYS_ROM  = 3'd3;
  localparam logic [2:0] SRC_BYTE     = 3'd4;

  // mode register codes
  localparam logic [1:0] MODE_ACTIVE   = 2'd0;
  localparam logic [1:0] MODE_ULTIMAX  = 2'd2;
  localparam logic [1:0] MODE_OFF      = 2'd3;

  typedef struct packed {
    logic        video_half;
    logic [12:0] address;
    logic        low_rom_select;
    logic        high_rom_select;
    logic        io_one_select;
    logic        io_two_select;
    logic        system_rom_select;
    logic        cpu_write;
    logic [7:0]  write_data;
    logic        freeze_button;
    logic        reset_held;
  } fcc_item_t;

  typedef struct packed {
    logic game;
    logic exrom;
    logic nmi;
    logic led;
    logic ultimax;
  } fcc_lines_t;

  localparam fcc_lines_t LINES_RESET = '{game: 1'b0, exrom: 1'b0, nmi: 1'b1,
                                         led: 1'b1, ultimax: 1'b0};

  typedef struct packed {
    logic        drive_bus;
    logic [2:0]  data_source;
    logic [12:0] rom_address;
    logic [7:0]  byte_out;
    logic        ram_read;
    logic        game_line;
    logic        exrom_line;
    logic        nmi_line;
    logic        led_on;
  } fcc_result_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [RAM_AW-1:0] addr;
    logic [7:0]        wdata;
  } fcc_ram_req_t;

  // line levels set by a mode write
  function automatic fcc_lines_t mode_lines(input logic [1:0] m);
    fcc_lines_t l;
    l.game    = m[0];
    l.exrom   = m[1];
    l.nmi     = 1'b1;
    l.led     = (m != MODE_OFF);
    l.ultimax = (m == MODE_ULTIMAX);
    return l;
  endfunction

  // 7-bit I/O offset folded into the RAM depth
  function automatic logic [RAM_AW-1:0] ram_index(input logic [6:0] v);
    logic [7:0] t;
    t = {1'b0, v};
    for (int i = 0; i < 8; i++) begin
      if (t >= RAM_DEPTH) t = t - 8'(RAM_DEPTH);
    end
    return t[RAM_AW-1:0];
  endfunction

endpackage

[hw/rtl/fcc_ram.sv]
// Generic single-port-write, registered-read RAM.
module fcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

[hw/rtl/fcc_core.sv]
// Bank logic state, bus decode and RAM request generation.
`include "assert_macros.svh"

module fcc_core
  import fcc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [18:0]  cfg_data,
  input  logic         accept,
  input  fcc_item_t    item,
  output fcc_result_t  res,
  output fcc_ram_req_t ram_req
);

  logic        has_system_rom;
  logic [18:0] debounce_cycles;
  logic [7:0]  reset_hold_min;

  logic [1:0]  mode;
  fcc_lines_t  lines;
  logic [2:0]  write_run;
  logic        freeze_pending;
  logic [18:0] debounce_count;
  logic [7:0]  hold_count;

  logic [1:0]  mode_next;
  fcc_lines_t  lines_next;
  logic [2:0]  write_run_next;
  logic        freeze_pending_next;
  logic [18:0] debounce_count_next;
  logic [7:0]  hold_count_next;

  always_comb begin
    logic [7:0]  off;
    fcc_result_t r;
    fcc_ram_req_t q;
    off                 = item.address[7:0];
    mode_next           = mode;
    lines_next          = lines;
    write_run_next      = write_run;
    freeze_pending_next = freeze_pending;
    debounce_count_next = debounce_count;
    hold_count_next     = hold_count;
    r                   = '0;
    q                   = '0;
    q.addr              = ram_index(off[6:0]);
    q.wdata             = item.write_data;

    if (item.video_half) begin
      if (item.high_rom_select) begin
        r.drive_bus   = 1'b1;
        r.data_source = SRC_HIGH_ROM;
        r.rom_address = item.address;
      end
    end else begin
      // host reset hold: a long enough hold reinitializes on release
      if (item.reset_held) begin
        if (hold_count != HOLD_COUNT_MAX) hold_count_next = hold_count + 8'd1;
      end else begin
        if (hold_count > reset_hold_min) begin
          mode_next           = MODE_ACTIVE;
          lines_next          = LINES_RESET;
          write_run_next      = '0;
          freeze_pending_next = 1'b0;
          debounce_count_next = '0;
        end
        hold_count_next = '0;
      end

      if (has_system_rom && item.high_rom_select && item.system_rom_select &&
          !lines_next.ultimax) begin
        r.drive_bus   = 1'b1;
        r.data_source = SRC_SYS_ROM;
        r.rom_address = item.address;
      end else if (!item.cpu_write && (item.low_rom_select || item.high_rom_select)) begin
        r.drive_bus   = 1'b1;
        r.data_source = item.high_rom_select ? SRC_HIGH_ROM : SRC_LOW_ROM;
        r.rom_address = item.address;
      end else if (!item.cpu_write && item.io_one_select) begin
        r.drive_bus   = 1'b1;
        r.data_source = SRC_LOW_ROM;
        r.rom_address = IO_ROM_PAGE | {5'd0, off};
        mode_next     = {off[1], 1'b1};
        lines_next    = mode_lines(mode_next);
      end else if (!item.cpu_write && item.io_two_select) begin
        r.drive_bus   = 1'b1;
        r.data_source = SRC_BYTE;
        if (off[7]) begin
          r.byte_out = {mode_next, 6'd0};
        end else begin
          q.re       = 1'b1;
          r.ram_read = 1'b1;
        end
      end else begin
        if (item.cpu_write) begin
          if (write_run_next != WRITE_RUN_MAX) write_run_next = write_run_next + 3'd1;
        end else begin
          write_run_next = '0;
        end

        if (item.cpu_write && item.io_one_select) begin
          mode_next  = {off[1], 1'b0};
          lines_next = mode_lines(mode_next);
        end

        if (item.cpu_write && item.io_two_select) begin
          q.we = !off[7];
        end else if (item.freeze_button && debounce_count_next == '0) begin
          debounce_count_next = debounce_cycles;
          freeze_pending_next = 1'b1;
          write_run_next      = '0;
          mode_next           = MODE_ULTIMAX;
          lines_next          = mode_lines(MODE_ULTIMAX);
          lines_next.nmi      = 1'b0;
        end else begin
          if (debounce_count_next != '0) debounce_count_next = debounce_count_next - 19'd1;
          // freeze handler's third write in a row drops back into ultimax
          if (freeze_pending_next && write_run_next == WRITE_RUN_TARGET) begin
            lines_next.exrom    = 1'b1;
            lines_next.game     = 1'b0;
            lines_next.ultimax  = 1'b1;
            freeze_pending_next = 1'b0;
          end
        end
      end
    end

    r.game_line  = lines_next.game;
    r.exrom_line = lines_next.exrom;
    r.nmi_line   = lines_next.nmi;
    r.led_on     = lines_next.led;
    res          = r;
    ram_req      = q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      has_system_rom  <= HAS_SYS_ROM_RESET;
      debounce_cycles <= DEBOUNCE_RESET;
      reset_hold_min  <= RESET_HOLD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HAS_SYSTEM_ROM:  has_system_rom  <= cfg_data[0];
        CFG_DEBOUNCE_CYCLES: debounce_cycles <= cfg_data;
        CFG_RESET_HOLD_MIN:  reset_hold_min  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_ACTIVE;
      lines          <= LINES_RESET;
      write_run      <= '0;
      freeze_pending <= 1'b0;
      debounce_count <= '0;
      hold_count     <= '0;
    end else if (accept) begin
      mode           <= mode_next;
      lines          <= lines_next;
      write_run      <= write_run_next;
      freeze_pending <= freeze_pending_next;
      debounce_count <= debounce_count_next;
      hold_count     <= hold_count_next;
    end
  end

  // NMI is pulled only by a freeze, which always enters ultimax
  `FCC_ASSERT(a_nmi_ultimax, clk, rst, !lines.nmi |-> lines.ultimax, "nmi low outside ultimax")
  `FCC_ASSERT(a_ram_one_op, clk, rst, !(ram_req.we && ram_req.re), "RAM read and write together")
  `FCC_ASSERT(a_pending_nmi, clk, rst, accept && item.freeze_button && !item.video_half && !res.drive_bus && !(item.cpu_write && item.io_two_select) && debounce_count == '0 && hold_count <= reset_hold_min |=> freeze_pending, "freeze press not taken")

endmodule

[hw/rtl/freezer_cartridge_controller_top.sv]
// Top level of the freezer cartridge controller: handshake, result register, scratch RAM.
//
//  channel   dir  handshake              payload
//  s_axis    in   s_tvalid / s_tready    s_tdata bus half-cycle, s_tuser video flag
//  m_axis    out  m_tvalid / m_tready    m_tdata response and lines, m_tuser source
//  cfg       in   cfg_we                 cfg_index, cfg_data
//
// One item per clock while m_tready does not hold a result back, with the result valid in the
// cycle after accept; scratch RAM reads come out of the registered RAM port, muxed in after res_q.
// rst is synchronous; scratch RAM contents are not cleared.
// A stalled result holds; a new item is taken in the same cycle the held one leaves.
`include "assert_macros.svh"

module freezer_cartridge_controller_top
  import fcc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [12:0] address, [13] low_rom_select, [14] high_rom_select, [15] io_one_select,
  // [16] io_two_select, [17] system_rom_select, [18] cpu_write, [26:19] write_data,
  // [27] freeze_button, [28] reset_held, [31:29] zero
  input  logic [31:0] s_tdata,
  // [0] video_half
  input  logic [0:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [0] drive_bus, [13:1] rom_address, [21:14] byte_out, [22] game_line,
  // [23] exrom_line, [24] nmi_line, [25] led_on, [31:26] zero
  output logic [31:0] m_tdata,
  // [2:0] data_source
  output logic [2:0]  m_tuser,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [18:0] cfg_data
);

  fcc_item_t    item;
  fcc_result_t  res;
  fcc_result_t  res_q;
  fcc_ram_req_t ram_req;
  logic         accept;
  logic [7:0]   ram_rdata;
  logic [7:0]   byte_out;

  assign item.video_half        = s_tuser[0];
  assign item.address           = s_tdata[12:0];
  assign item.low_rom_select    = s_tdata[13];
  assign item.high_rom_select   = s_tdata[14];
  assign item.io_one_select     = s_tdata[15];
  assign item.io_two_select     = s_tdata[16];
  assign item.system_rom_select = s_tdata[17];
  assign item.cpu_write         = s_tdata[18];
  assign item.write_data        = s_tdata[26:19];
  assign item.freeze_button     = s_tdata[27];
  assign item.reset_held        = s_tdata[28];

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  fcc_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .item      (item),
    .res       (res),
    .ram_req   (ram_req)
  );

  fcc_ram #(
    .WIDTH (8),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (accept && ram_req.we),
    .waddr (ram_req.addr),
    .wdata (ram_req.wdata),
    .re    (accept && ram_req.re),
    .raddr (ram_req.addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) res_q <= res;
  end

  // RAM data stays on the port until the next read, so it holds through a stall
  assign byte_out = res_q.ram_read ? ram_rdata : res_q.byte_out;

  assign m_tdata = {6'd0, res_q.led_on, res_q.nmi_line, res_q.exrom_line, res_q.game_line,
                    byte_out, res_q.rom_address, res_q.drive_bus};
  assign m_tuser = res_q.data_source;

  `FCC_ASSERT(a_accept_to_out, clk, rst, accept |=> m_tvalid, "accepted item gave no result")
  `FCC_ASSERT(a_idle_no_source, clk, rst, m_tvalid && !m_tdata[0] |-> m_tuser == SRC_NONE, "source named without driving")
  `FCC_ASSERT(a_byte_only_src4, clk, rst, m_tvalid && m_tuser != SRC_BYTE |-> m_tdata[21:14] == 8'd0, "byte out outside byte source")
  `FCC_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !m_tvalid, "result valid after reset")

endmodule
